// File: hdl/bfbp_pkg.sv
// ----------------------------------------------------------------------------
// Best-fit bin packer package
// Shared constants and codes for the best-fit bin packer core.
// ----------------------------------------------------------------------------
`default_nettype none

package bfbp_pkg;

  localparam int unsigned MAX_BINS_DEFAULT = 256;

  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [SIZE_W-1:0] CAPACITY_RESET = 16'hFFFF;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_PLACED  = 2'd0,
    STATUS_TOO_BIG = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    REG_BIN_CAPACITY = 1'b0
  } reg_index_t;

endpackage

`default_nettype wire

// File: hdl/best_fit_bin_packer_core.sv
// ----------------------------------------------------------------------------
// Best-fit bin packer core
// Online best-fit placement of items into bins, one comparator scanning the
// stored free space of the open bins.
// ----------------------------------------------------------------------------
// Flow: an accepted item has the free space of each open bin (after any new
// set) read from a registered memory and compared; the decision then waits
// for a free output, and an item larger than the capacity skips the scan. The
// next item is accepted once a result is presented; a stalled result delays the next one.
// Reset clears the bin count and control state and sets the capacity to
// 65535; the free-space memory is not cleared and is only read below the count.
`default_nettype none

module best_fit_bin_packer_core #(
  parameter int unsigned MAX_BINS = bfbp_pkg::MAX_BINS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [bfbp_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [bfbp_pkg::PDATA_W-1:0]    pwdata,
  output logic      [bfbp_pkg::PDATA_W-1:0]    prdata,
  output logic                                 pready,
  input  wire logic                            item_valid,
  output logic                                 item_stall,
  input  wire logic [bfbp_pkg::SIZE_W-1:0]     item_size,
  input  wire logic                            new_set,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output logic      [bfbp_pkg::INDEX_W-1:0]    bin_index,
  output logic                                 opened_new,
  output logic      [bfbp_pkg::COUNT_W-1:0]    bins_used,
  output logic      [bfbp_pkg::STATUS_W-1:0]   status
);

  localparam int unsigned IW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned CW = $clog2(MAX_BINS + 1);
  localparam int unsigned SW = bfbp_pkg::SIZE_W;

  localparam logic REG_BIN_CAPACITY_BIT = bfbp_pkg::REG_BIN_CAPACITY;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  state_t          state;
  logic [SW-1:0]   bin_capacity;
  logic [SW-1:0]   size;
  logic            too_big;
  logic [CW-1:0]   open_count;
  logic [CW-1:0]   issue_cnt;
  logic            rd_valid;
  logic [IW-1:0]   rd_idx;
  logic            found;
  logic [SW-1:0]   best;
  logic [IW-1:0]   best_idx;

  logic [SW-1:0]   remaining_space [MAX_BINS];
  logic [SW-1:0]   mem_rdata;
  logic            mem_re;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  logic [SW-1:0]   mem_wdata;

  logic            item_accept;
  logic            cfg_write;
  logic            decide_go;
  logic            out_free;
  logic            fits;
  logic            better;
  logic            table_full;

  assign pready      = 1'b1;
  assign cfg_write   = psel && penable && pwrite;
  assign item_stall  = (state != ST_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign out_free    = !result_valid || !result_stall;
  assign decide_go   = (state == ST_DECIDE) && out_free;
  assign table_full  = (open_count == CW'(MAX_BINS));

  assign fits   = (mem_rdata >= size);
  assign better = fits && (!found || (mem_rdata < best));

  assign mem_re = (state == ST_SCAN) && (issue_cnt != open_count);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = best_idx;
    mem_wdata = best - size;
    if (decide_go && !too_big) begin
      if (found) begin
        mem_we = 1'b1;
      end else if (!table_full) begin
        mem_we    = 1'b1;
        mem_waddr = open_count[IW-1:0];
        mem_wdata = bin_capacity - size;
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_BIN_CAPACITY_BIT) begin
      prdata = {{(bfbp_pkg::PDATA_W-SW){1'b0}}, bin_capacity};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      remaining_space[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= remaining_space[issue_cnt[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_capacity <= bfbp_pkg::CAPACITY_RESET;
    end else if (cfg_write && (paddr[2] == REG_BIN_CAPACITY_BIT)) begin
      bin_capacity <= pwdata[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      open_count   <= '0;
      issue_cnt    <= '0;
      rd_valid     <= 1'b0;
      found        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && !decide_go) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_accept) begin
            size      <= item_size;
            too_big   <= (item_size > bin_capacity);
            issue_cnt <= '0;
            rd_valid  <= 1'b0;
            found     <= 1'b0;
            if (new_set) begin
              open_count <= '0;
            end
            state <= (item_size > bin_capacity) ? ST_DECIDE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_valid <= mem_re;
          rd_idx   <= issue_cnt[IW-1:0];
          if (mem_re) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (rd_valid && better) begin
            found    <= 1'b1;
            best     <= mem_rdata;
            best_idx <= rd_idx;
          end
          if (!mem_re && !rd_valid) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (decide_go) begin
            result_valid <= 1'b1;
            if (too_big) begin
              bin_index  <= '0;
              opened_new <= 1'b0;
              bins_used  <= bfbp_pkg::COUNT_W'(open_count);
              status     <= bfbp_pkg::STATUS_TOO_BIG;
            end else if (found) begin
              bin_index  <= bfbp_pkg::INDEX_W'(best_idx);
              opened_new <= 1'b0;
              bins_used  <= bfbp_pkg::COUNT_W'(open_count);
              status     <= bfbp_pkg::STATUS_PLACED;
            end else if (table_full) begin
              bin_index  <= '0;
              opened_new <= 1'b0;
              bins_used  <= bfbp_pkg::COUNT_W'(open_count);
              status     <= bfbp_pkg::STATUS_FULL;
            end else begin
              bin_index  <= bfbp_pkg::INDEX_W'(open_count);
              opened_new <= 1'b1;
              bins_used  <= bfbp_pkg::COUNT_W'(open_count + 1'b1);
              status     <= bfbp_pkg::STATUS_PLACED;
              open_count <= open_count + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    open_count <= CW'(MAX_BINS))
    else $error("bin count exceeds the table size");

  a_new_set_clears: assert property (@(posedge clk) disable iff (rst)
    item_accept && new_set |=> open_count == '0)
    else $error("new set did not empty the bins");

  a_opened_placed: assert property (@(posedge clk) disable iff (rst)
    result_valid && opened_new |-> status == bfbp_pkg::STATUS_PLACED)
    else $error("new bin reported with an error status");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status == bfbp_pkg::STATUS_PLACED ||
                      status == bfbp_pkg::STATUS_TOO_BIG ||
                      status == bfbp_pkg::STATUS_FULL))
    else $error("undefined status code");

endmodule

`default_nettype wire

// File: bench/bfbp_placement_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit bin packer placement checker
// Watches the configuration port and both item channels of the packer,
// keeps its own copy of the bin table and works out the placement for every
// accepted item, then compares each returned result with the oldest one due.
// ----------------------------------------------------------------------------

module bfbp_placement_checker #(
  parameter int unsigned MAX_BINS = bfbp_pkg::MAX_BINS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic                            pready,
  input  wire logic [bfbp_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [bfbp_pkg::PDATA_W-1:0]    pwdata,
  input  wire logic                            item_valid,
  input  wire logic                            item_stall,
  input  wire logic [bfbp_pkg::SIZE_W-1:0]     item_size,
  input  wire logic                            new_set,
  input  wire logic                            result_valid,
  input  wire logic                            result_stall,
  input  wire logic [bfbp_pkg::INDEX_W-1:0]    bin_index,
  input  wire logic                            opened_new,
  input  wire logic [bfbp_pkg::COUNT_W-1:0]    bins_used,
  input  wire logic [bfbp_pkg::STATUS_W-1:0]   status,
  output int                                   pending,
  output int                                   failures
);

  typedef struct packed {
    logic [bfbp_pkg::INDEX_W-1:0] bin_index;
    logic                         opened_new;
    logic [bfbp_pkg::COUNT_W-1:0] bins_used;
    bfbp_pkg::status_t            status;
  } placement_t;

  logic [bfbp_pkg::SIZE_W-1:0] capacity;
  logic [bfbp_pkg::SIZE_W-1:0] bin_space [MAX_BINS];
  int unsigned                 open_bins;
  placement_t                  expected_placements [$];
  int                          fail_count = 0;

  function automatic placement_t place_item(input logic [bfbp_pkg::SIZE_W-1:0] size,
                                            input logic fresh);
    placement_t                  res;
    int unsigned                 pick;
    logic [bfbp_pkg::SIZE_W-1:0] tightest;
    bit                          hit;
    res      = '0;
    res.status = bfbp_pkg::STATUS_PLACED;
    pick     = 0;
    tightest = '0;
    hit      = 1'b0;
    if (fresh) begin
      open_bins = 0;
    end
    if (size > capacity) begin
      res.status = bfbp_pkg::STATUS_TOO_BIG;
    end else begin
      for (int unsigned i = 0; i < open_bins; i++) begin
        if (bin_space[i] >= size && (!hit || bin_space[i] < tightest)) begin
          hit      = 1'b1;
          tightest = bin_space[i];
          pick     = i;
        end
      end
      if (hit) begin
        bin_space[pick] = tightest - size;
        res.bin_index   = bfbp_pkg::INDEX_W'(pick);
      end else if (open_bins >= MAX_BINS) begin
        res.status = bfbp_pkg::STATUS_FULL;
      end else begin
        bin_space[open_bins] = capacity - size;
        res.bin_index        = bfbp_pkg::INDEX_W'(open_bins);
        res.opened_new       = 1'b1;
        open_bins++;
      end
    end
    res.bins_used = bfbp_pkg::COUNT_W'(open_bins);
    return res;
  endfunction

  always @(posedge clk) begin
    placement_t due;
    if (rst) begin
      capacity  = bfbp_pkg::CAPACITY_RESET;
      open_bins = 0;
      expected_placements.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          int'(paddr >> 2) == int'(bfbp_pkg::REG_BIN_CAPACITY)) begin
        capacity = pwdata[bfbp_pkg::SIZE_W-1:0];
      end
      if (result_valid && !result_stall) begin
        if (expected_placements.size() == 0) begin
          $display("%0t: result with no item outstanding (bin %0d, used %0d, status %0d)",
                   $time, bin_index, bins_used, status);
          fail_count++;
        end else begin
          due = expected_placements.pop_front();
          if (bin_index !== due.bin_index) begin
            $display("%0t: bin_index expected %0d got %0d", $time, due.bin_index, bin_index);
            fail_count++;
          end
          if (opened_new !== due.opened_new) begin
            $display("%0t: opened_new expected %0d got %0d", $time, due.opened_new,
                     opened_new);
            fail_count++;
          end
          if (bins_used !== due.bins_used) begin
            $display("%0t: bins_used expected %0d got %0d", $time, due.bins_used, bins_used);
            fail_count++;
          end
          if (status !== due.status) begin
            $display("%0t: status expected %0d got %0d", $time, due.status, status);
            fail_count++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        expected_placements.insert(expected_placements.size(),
                                   place_item(item_size, new_set));
      end
    end
    pending  <= expected_placements.size();
    failures <= fail_count;
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit bin packer testbench
// Drives directed and random items through the packer under several bin
// capacities, with random gaps on the input and random stalls on the output,
// and reports the verdict from the placement checker.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int unsigned MAX_BINS     = bfbp_pkg::MAX_BINS_DEFAULT;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned EPISODES     = 8;
  localparam int unsigned SETTLE       = MAX_BINS + 40;
  localparam int unsigned CYCLE_LIMIT  = 4000000;

  localparam logic [bfbp_pkg::PADDR_W-1:0] ADDR_CAPACITY =
    bfbp_pkg::PADDR_W'(4 * int'(bfbp_pkg::REG_BIN_CAPACITY));
  localparam logic [bfbp_pkg::PADDR_W-1:0] ADDR_UNMAPPED =
    bfbp_pkg::PADDR_W'(4 * (int'(bfbp_pkg::REG_BIN_CAPACITY) + 1));

  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          psel         = 1'b0;
  logic                          penable      = 1'b0;
  logic                          pwrite       = 1'b0;
  logic [bfbp_pkg::PADDR_W-1:0]  paddr        = '0;
  logic [bfbp_pkg::PDATA_W-1:0]  pwdata       = '0;
  logic [bfbp_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;
  logic                          item_valid   = 1'b0;
  logic                          item_stall;
  logic [bfbp_pkg::SIZE_W-1:0]   item_size    = '0;
  logic                          new_set      = 1'b0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  logic [bfbp_pkg::INDEX_W-1:0]  bin_index;
  logic                          opened_new;
  logic [bfbp_pkg::COUNT_W-1:0]  bins_used;
  logic [bfbp_pkg::STATUS_W-1:0] status;

  int          pending;
  int          mismatches;
  int unsigned cycle_count = 0;
  int unsigned stall_run   = 0;
  int unsigned cur_cap     = 65535;
  bit          calm        = 1'b0;

  best_fit_bin_packer_core #(.MAX_BINS(MAX_BINS)) dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .item_valid, .item_stall, .item_size, .new_set,
    .result_valid, .result_stall, .bin_index, .opened_new, .bins_used, .status
  );

  bfbp_placement_checker #(.MAX_BINS(MAX_BINS)) placement_check (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .item_valid, .item_stall, .item_size, .new_set,
    .result_valid, .result_stall, .bin_index, .opened_new, .bins_used, .status,
    .pending, .failures(mismatches)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_run    <= 0;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin : pick_stall
      int unsigned r;
      r = $urandom_range(99, 0);
      if (calm || r < 55) begin
        result_stall <= 1'b0;
        stall_run    <= $urandom_range(8, 0);
      end else if (r < 88) begin
        result_stall <= 1'b1;
        stall_run    <= $urandom_range(2, 0);
      end else if (r < 98) begin
        result_stall <= 1'b1;
        stall_run    <= $urandom_range(12, 3);
      end else begin
        result_stall <= 1'b1;
        stall_run    <= $urandom_range(60, 20);
      end
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [bfbp_pkg::SIZE_W-1:0] pick_size(input int unsigned cap);
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 2) return '0;
    if (r < 10 && cap < 65535) return bfbp_pkg::SIZE_W'($urandom_range(65535, cap + 1));
    if (cap == 0) return bfbp_pkg::SIZE_W'($urandom_range(65535, 1));
    if (r < 20) return bfbp_pkg::SIZE_W'(cap);
    if (r < 40) return bfbp_pkg::SIZE_W'($urandom_range(cap / 8 + 1, 1));
    return bfbp_pkg::SIZE_W'($urandom_range(cap, 1));
  endfunction

  task automatic push_item(input logic [bfbp_pkg::SIZE_W-1:0] size, input logic fresh);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item_size  <= size;
    new_set    <= fresh;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bfbp_pkg::PADDR_W-1:0] addr, input int unsigned data);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= bfbp_pkg::PDATA_W'(data);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_CAPACITY) begin
      cur_cap = data & 32'hFFFF;
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned set_left;
    int unsigned r;
    int unsigned caps [EPISODES];

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_item(16'hFFFF, 1'b1);
    push_item(16'd0, 1'b0);
    push_item(16'd1, 1'b0);
    push_item(16'hFFFF, 1'b0);
    push_item(16'h8000, 1'b1);
    push_item(16'h7FFF, 1'b0);
    push_item(16'd1, 1'b0);

    write_reg(ADDR_CAPACITY, 100);
    push_item(16'd101, 1'b0);
    push_item(16'd150, 1'b1);
    push_item(16'd60, 1'b0);
    push_item(16'd60, 1'b0);
    push_item(16'd40, 1'b0);
    push_item(16'd30, 1'b0);
    push_item(16'd10, 1'b0);
    push_item(16'd100, 1'b0);

    write_reg(ADDR_UNMAPPED, 5);
    push_item(16'd101, 1'b0);
    push_item(16'd100, 1'b1);

    write_reg(ADDR_CAPACITY, 0);
    push_item(16'd1, 1'b1);
    push_item(16'd0, 1'b0);
    push_item(16'd0, 1'b0);

    // Fill the whole bin table with unit items, overflow it once, then
    // check that an empty item still lands in the fullest open bin.
    write_reg(ADDR_CAPACITY, 1);
    push_item(16'd1, 1'b1);
    repeat (MAX_BINS) push_item(16'd1, 1'b0);
    push_item(16'd0, 1'b0);
    push_item(16'd2, 1'b0);
    push_item(16'd1, 1'b1);

    caps[0] = 65535;
    caps[1] = 1;
    caps[2] = $urandom_range(16, 2);
    caps[3] = $urandom_range(2000, 100);
    caps[4] = $urandom_range(65535, 1);
    caps[5] = 65535;
    caps[6] = $urandom_range(300, 50);
    caps[7] = $urandom_range(65534, 30000);

    sent     = 0;
    set_left = 0;
    for (int unsigned e = 0; e < EPISODES; e++) begin
      calm = (e == 1 || e == 5);
      write_reg(ADDR_CAPACITY, caps[e]);
      while (sent < (e + 1) * RANDOM_ITEMS / EPISODES) begin
        if (set_left == 0) begin
          r = $urandom_range(99, 0);
          if (r < 70) set_left = $urandom_range(15, 1);
          else if (r < 95) set_left = $urandom_range(60, 16);
          else set_left = $urandom_range(300, 100);
          push_item(pick_size(cur_cap), 1'b1);
        end else begin
          push_item(pick_size(cur_cap), 1'b0);
        end
        set_left--;
        sent++;
      end
    end
    calm = 1'b0;

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
